### hdl/sliding_window_sender_top_defines.svh
// Assertion macros shared by the sliding-window sender modules.
`ifndef SLIDING_WINDOW_SENDER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SWS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window sender assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window sender assertion failed");

`endif

### hdl/sws_pkg.sv
// Types, codes and constants shared by the sliding-window sender modules.
package sws_pkg;

   localparam int WINDOW_DEPTH_DEF = 8;
   localparam int SEQ_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 64;

   localparam int FUNC_W      = 2;
   localparam int PAYLOAD_W   = 64;
   localparam int SEQ_W       = 16;
   localparam int CSR_W       = 4;
   localparam int MAX_RESULTS = 4;
   localparam int RIDX_W      = 2;

   localparam logic [CSR_W-1:0] WINDOW_SIZE_RESET = 4'd4;
   localparam logic [1:0]       DUP_LIMIT         = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SEND    = 2'd0,
      FUNC_ACK     = 2'd1,
      FUNC_TIMEOUT = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_XMIT   = 2'd1,
      KIND_START  = 2'd2,
      KIND_STOP   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [PAYLOAD_W-1:0] payload;
      logic [SEQ_W-1:0]     ack_num;
      logic                 checksum_ok;
      logic [SEQ_W-1:0]     timer_seq;
   } req_type;

   typedef struct packed {
      kind_type             kind;
      logic                 accepted;
      logic [SEQ_W-1:0]     seq_num;
      logic [PAYLOAD_W-1:0] packet_data;
      logic                 last;
   } rsp_type;

   typedef logic [CSR_W-1:0] csr_type;

   typedef struct packed {
      kind_type [MAX_RESULTS-1:0]             kind_list;
      logic     [MAX_RESULTS-1:0][SEQ_W-1:0]  seq_list;
      logic     [RIDX_W-1:0]                  last_idx;
      logic                                   accepted;
      logic     [PAYLOAD_W-1:0]               data;
   } plan_type;

endpackage

### hdl/sws_chan_if.sv
// Valid/ready channel interface carrying one payload of a chosen type.
interface sws_chan_if #(
   parameter type data_type = logic
) ();
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/sws_front.sv
// Front end: accepts requests, keeps the window state and plans the results.
`include "sliding_window_sender_top_defines.svh"

module sws_front #(
   parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF,
   parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   sws_chan_if.sink           req_if,
   sws_chan_if.sink           csr_if,
   output logic               push_valid,
   input  logic               push_ready,
   output sws_pkg::plan_type  push_plan
);
   import sws_pkg::*;

   localparam int     RING_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int     CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam longint SEQ_MAX   = (longint'(1) << SEQ_BITS) - 1;
   localparam int     WIN_CAP   = (longint'(WINDOW_DEPTH) < SEQ_MAX) ? WINDOW_DEPTH
                                                                    : int'(SEQ_MAX);

   logic [CSR_W-1:0]        win_size_ff;
   logic [SEQ_BITS-1:0]     base_ff, base_in;
   logic [SEQ_BITS-1:0]     next_ff, next_in;
   logic [1:0]              dup_ff, dup_in;
   logic [RING_BITS-1:0]    head_ff, head_in;
   logic                    s1_valid_ff, s1_valid_in;
   plan_type                s1_plan_ff, plan_in;
   logic                    s1_mem_ff, mem_in;
   logic [PAYLOAD_BITS-1:0] store_ff [WINDOW_DEPTH];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   logic                    req_ready, accept, has_result, wr_en;
   logic [RING_BITS-1:0]    wr_addr;
   logic [SEQ_BITS-1:0]     outs, eff, win_ext, cap_c, ack, ack_off, tseq, base_adv;
   logic [PAYLOAD_BITS-1:0] pay;
   logic [CNT_BITS:0]       depth_c, wr_sum, head_sum;
   logic [1:0]              dup_sat;

   assign req_ready     = !s1_valid_ff || push_ready;
   assign accept        = req_if.valid && req_ready;
   assign req_if.ready  = req_ready;
   assign csr_if.ready  = 1'b1;

   assign outs     = next_ff - base_ff;
   assign win_ext  = SEQ_BITS'(win_size_ff);
   assign cap_c    = SEQ_BITS'(WIN_CAP);
   assign eff      = (win_ext > cap_c) ? cap_c : win_ext;
   assign ack      = SEQ_BITS'(req_if.data.ack_num);
   assign tseq     = SEQ_BITS'(req_if.data.timer_seq);
   assign ack_off  = ack - base_ff;
   assign base_adv = ack + SEQ_BITS'(1);
   assign pay      = req_if.data.payload[PAYLOAD_BITS-1:0];
   assign depth_c  = (CNT_BITS+1)'(WINDOW_DEPTH);
   assign wr_sum   = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(outs);
   assign head_sum = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(ack_off) + (CNT_BITS+1)'(1);
   assign wr_addr  = RING_BITS'((wr_sum >= depth_c) ? wr_sum - depth_c : wr_sum);
   assign dup_sat  = (dup_ff == DUP_LIMIT) ? DUP_LIMIT : dup_ff + 2'd1;

   always_comb begin
      plan_in    = '0;
      mem_in     = 1'b0;
      has_result = 1'b0;
      wr_en      = 1'b0;
      base_in    = base_ff;
      next_in    = next_ff;
      dup_in     = dup_ff;
      head_in    = head_ff;
      case (req_if.data.func)
         FUNC_SEND: begin
            has_result = 1'b1;
            if (outs >= eff) begin
               plan_in.kind_list[0] = KIND_STATUS;
               plan_in.last_idx     = 2'd0;
            end else begin
               wr_en            = accept;
               next_in          = next_ff + SEQ_BITS'(1);
               plan_in.accepted = 1'b1;
               plan_in.data     = PAYLOAD_W'(pay);
               if (outs == '0) begin
                  plan_in.kind_list[0] = KIND_START;
                  plan_in.seq_list[0]  = SEQ_W'(next_ff);
                  plan_in.kind_list[1] = KIND_XMIT;
                  plan_in.seq_list[1]  = SEQ_W'(next_ff);
                  plan_in.kind_list[2] = KIND_STATUS;
                  plan_in.last_idx     = 2'd2;
               end else begin
                  plan_in.kind_list[0] = KIND_XMIT;
                  plan_in.seq_list[0]  = SEQ_W'(next_ff);
                  plan_in.kind_list[1] = KIND_STATUS;
                  plan_in.last_idx     = 2'd1;
               end
            end
         end
         FUNC_ACK: begin
            if (req_if.data.checksum_ok && (ack_off < outs)) begin
               has_result           = 1'b1;
               plan_in.kind_list[0] = KIND_STOP;
               plan_in.seq_list[0]  = SEQ_W'(base_ff);
               if (ack_off != '0) begin
                  base_in = base_adv;
                  head_in = RING_BITS'((head_sum >= depth_c) ? head_sum - depth_c
                                                              : head_sum);
                  dup_in  = 2'd1;
                  if (base_adv != next_ff) begin
                     plan_in.kind_list[1] = KIND_START;
                     plan_in.seq_list[1]  = SEQ_W'(base_adv);
                     plan_in.last_idx     = 2'd1;
                  end
               end else begin
                  dup_in = dup_sat;
                  if (dup_sat == DUP_LIMIT) begin
                     mem_in               = 1'b1;
                     plan_in.kind_list[1] = KIND_STOP;
                     plan_in.seq_list[1]  = SEQ_W'(base_ff);
                     plan_in.kind_list[2] = KIND_XMIT;
                     plan_in.seq_list[2]  = SEQ_W'(base_ff);
                     plan_in.kind_list[3] = KIND_START;
                     plan_in.seq_list[3]  = SEQ_W'(base_ff);
                     plan_in.last_idx     = 2'd3;
                  end
               end
            end
         end
         FUNC_TIMEOUT: begin
            has_result           = 1'b1;
            plan_in.kind_list[0] = KIND_STOP;
            plan_in.seq_list[0]  = SEQ_W'(tseq);
            if (outs != '0) begin
               mem_in               = 1'b1;
               plan_in.kind_list[1] = KIND_XMIT;
               plan_in.seq_list[1]  = SEQ_W'(base_ff);
               plan_in.kind_list[2] = KIND_START;
               plan_in.seq_list[2]  = SEQ_W'(tseq);
               plan_in.last_idx     = 2'd2;
            end
         end
         default: begin
         end
      endcase
   end

   assign s1_valid_in = req_ready ? (accept && has_result) : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= WINDOW_SIZE_RESET;
         base_ff     <= '0;
         next_ff     <= '0;
         dup_ff      <= '0;
         head_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_if.valid) begin
            win_size_ff <= csr_if.data;
         end
         if (accept) begin
            base_ff <= base_in;
            next_ff <= next_in;
            dup_ff  <= dup_in;
            head_ff <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_plan_ff <= plan_in;
         s1_mem_ff  <= mem_in;
         rd_data_ff <= store_ff[head_ff];
      end
      if (wr_en) begin
         store_ff[wr_addr] <= pay;
      end
   end

   always_comb begin
      push_valid = s1_valid_ff;
      push_plan  = s1_plan_ff;
      if (s1_mem_ff) begin
         push_plan.data = PAYLOAD_W'(rd_data_ff);
      end
   end

   `SWS_ASSERT_IMP(a_outs_cap, clock, reset, 1'b1, outs <= cap_c)
   `SWS_ASSERT_IMP(a_head_range, clock, reset, 1'b1, int'(head_ff) < WINDOW_DEPTH)
   `SWS_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !push_ready, s1_valid_ff && $stable(s1_plan_ff))

endmodule

### hdl/sws_queue.sv
// Short queue of planned result groups between the front and back ends.
module sws_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sws_pkg::plan_type  push_plan,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sws_pkg::plan_type  pop_plan
);
   import sws_pkg::*;

   plan_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_plan   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

endmodule

### hdl/sws_back.sv
// Back end: walks each planned group and drives one result per cycle while the result channel is ready.
`include "sliding_window_sender_top_defines.svh"

module sws_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  sws_pkg::plan_type  pop_plan,
   sws_chan_if.source         rsp_if
);
   import sws_pkg::*;

   logic [RIDX_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              load;
   kind_type          kind_c;

   assign load          = pop_valid && (!rsp_valid_ff || rsp_if.ready);
   assign kind_c        = pop_plan.kind_list[idx_ff];
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.data   = rsp_data_ff;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      pop_ready    = 1'b0;
      if (load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.kind        = kind_c;
         rsp_data_in.seq_num     = pop_plan.seq_list[idx_ff];
         rsp_data_in.accepted    = (kind_c == KIND_STATUS) && pop_plan.accepted;
         rsp_data_in.packet_data = (kind_c == KIND_XMIT) ? pop_plan.data : '0;
         rsp_data_in.last        = idx_ff == pop_plan.last_idx;
         if (idx_ff == pop_plan.last_idx) begin
            pop_ready = 1'b1;
            idx_in    = '0;
         end else begin
            idx_in = idx_ff + RIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   `SWS_ASSERT_IMP(a_idx_head, clock, reset, idx_ff != '0, pop_valid && (idx_ff <= pop_plan.last_idx))

endmodule

### hdl/sliding_window_sender_top.sv
// Top level of the go-back-N sliding-window sender with fast retransmit.
//
//   channel  direction  carries
//   req_if   in         send, ack arrival or timer expiry request
//   rsp_if   out        status, transmit and timer results
//   csr_if   in         window size register write
//
// A request is taken in every cycle while the result queue has room.
// Each request yields zero to four results, one per cycle from the output register
// while the result channel is ready; plans pass the front-end register and the queue.
// The window store needs no clearing after reset.
// A stalled result channel fills the two-entry queue and then holds off requests.
module sliding_window_sender_top #(
   parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF,
   parameter int SEQ_BITS     = sws_pkg::SEQ_BITS_DEF,
   parameter int PAYLOAD_BITS = sws_pkg::PAYLOAD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sws_chan_if.sink    req_if,
   sws_chan_if.source  rsp_if,
   sws_chan_if.sink    csr_if
);
   import sws_pkg::*;

   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;
   plan_type push_plan, pop_plan;

   sws_front #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_plan  (push_plan)
   );

   sws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_plan  (push_plan),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_plan   (pop_plan)
   );

   sws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_plan  (pop_plan),
      .rsp_if    (rsp_if)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for the go-back-N sliding-window sender.
`timescale 1ns / 1ps

module testbench;
   import sws_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 42;

   class window_scoreboard;
      csr_type              size_reg;
      logic [SEQ_W-1:0]     base_seq;
      logic [SEQ_W-1:0]     next_seq;
      logic [1:0]           dup_count;
      logic [PAYLOAD_W-1:0] packet_store [WINDOW_DEPTH_DEF];
      int                   head;
      rsp_type              expected_events [$];
      int                   failures;

      function new();
         size_reg = WINDOW_SIZE_RESET;
         base_seq = '0;
         next_seq = '0;
         dup_count = '0;
         head = 0;
         failures = 0;
      endfunction

      function logic [SEQ_W-1:0] outstanding();
         return next_seq - base_seq;
      endfunction

      function int window_limit();
         return (size_reg > WINDOW_DEPTH_DEF) ? WINDOW_DEPTH_DEF : int'(size_reg);
      endfunction

      function void expect_event(kind_type k, logic acc, logic [SEQ_W-1:0] s,
                                 logic [PAYLOAD_W-1:0] d);
         rsp_type e;
         e.kind = k;
         e.accepted = acc;
         e.seq_num = s;
         e.packet_data = d;
         e.last = 1'b0;
         expected_events.insert(expected_events.size(), e);
      endfunction

      function void note_request(req_type r);
         logic [SEQ_W-1:0] outs;
         logic [SEQ_W-1:0] offset;
         rsp_type          final_event;
         int               first;
         first = expected_events.size();
         outs = outstanding();
         case (r.func)
            FUNC_SEND: begin
               if (outs >= window_limit()) begin
                  expect_event(KIND_STATUS, 1'b0, '0, '0);
               end else begin
                  packet_store[(head + outs) % WINDOW_DEPTH_DEF] = r.payload;
                  if (outs == 0) expect_event(KIND_START, 1'b0, next_seq, '0);
                  expect_event(KIND_XMIT, 1'b0, next_seq, r.payload);
                  expect_event(KIND_STATUS, 1'b1, '0, '0);
                  next_seq = next_seq + 1'b1;
               end
            end
            FUNC_ACK: begin
               offset = r.ack_num - base_seq;
               if (r.checksum_ok && offset < outs) begin
                  expect_event(KIND_STOP, 1'b0, base_seq, '0);
                  if (offset != 0) begin
                     base_seq = base_seq + offset + 1'b1;
                     head = (head + offset + 1) % WINDOW_DEPTH_DEF;
                     dup_count = 2'd1;
                     if (base_seq != next_seq) expect_event(KIND_START, 1'b0, base_seq, '0);
                  end else begin
                     if (dup_count < DUP_LIMIT) dup_count = dup_count + 1'b1;
                     if (dup_count == DUP_LIMIT) begin
                        expect_event(KIND_STOP, 1'b0, base_seq, '0);
                        expect_event(KIND_XMIT, 1'b0, base_seq, packet_store[head]);
                        expect_event(KIND_START, 1'b0, base_seq, '0);
                     end
                  end
               end
            end
            FUNC_TIMEOUT: begin
               expect_event(KIND_STOP, 1'b0, r.timer_seq, '0);
               if (outs != 0) begin
                  expect_event(KIND_XMIT, 1'b0, base_seq, packet_store[head]);
                  expect_event(KIND_START, 1'b0, r.timer_seq, '0);
               end
            end
            default: ;
         endcase
         if (expected_events.size() > first) begin
            final_event = expected_events[expected_events.size() - 1];
            final_event.last = 1'b1;
            expected_events[expected_events.size() - 1] = final_event;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_events.size() == 0) begin
            $error("unexpected result: kind %0d seq_num %0d", got.kind, got.seq_num);
            failures++;
            return;
         end
         want = expected_events[0];
         expected_events.delete(0);
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            failures++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            failures++;
         end
         if (got.seq_num !== want.seq_num) begin
            $error("seq_num: expected %0d, got %0d", want.seq_num, got.seq_num);
            failures++;
         end
         if (got.packet_data !== want.packet_data) begin
            $error("packet_data: expected %h, got %h", want.packet_data, got.packet_data);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   rsp_hold_cycles = 0;
   bit   send_idle = 1'b1;
   bit   recv_idle = 1'b1;

   window_scoreboard sb = new();

   sws_chan_if #(.data_type(req_type)) req_if ();
   sws_chan_if #(.data_type(rsp_type)) rsp_if ();
   sws_chan_if #(.data_type(csr_type)) csr_if ();

   sliding_window_sender_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_type build_request(logic [FUNC_W-1:0] f, logic [PAYLOAD_W-1:0] pay,
                                             logic [SEQ_W-1:0] ack, logic ok,
                                             logic [SEQ_W-1:0] tseq);
      req_type r;
      r.func = f;
      r.payload = pay;
      r.ack_num = ack;
      r.checksum_ok = ok;
      r.timer_seq = tseq;
      return r;
   endfunction

   // Mostly well-formed traffic built from the current window, with some noise mixed in.
   function automatic req_type random_request();
      req_type          r;
      logic [SEQ_W-1:0] outs;
      int               pick;
      outs = sb.outstanding();
      r.func = FUNC_SEND;
      r.payload = {$urandom, $urandom};
      r.ack_num = SEQ_W'($urandom);
      r.checksum_ok = 1'b1;
      r.timer_seq = SEQ_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.func = FUNC_SEND;
      end else if (pick < 75) begin
         r.func = FUNC_ACK;
         if (outs != 0) begin
            if ($urandom_range(0, 1) == 0) r.ack_num = sb.base_seq;
            else r.ack_num = SEQ_W'(sb.base_seq + $urandom_range(0, outs - 1));
         end
      end else if (pick < 85) begin
         r.func = FUNC_TIMEOUT;
         if (pick < 80) r.timer_seq = sb.base_seq;
      end else if (pick < 90) begin
         r.func = FUNC_ACK;
         r.checksum_ok = 1'b0;
         if (outs != 0) r.ack_num = sb.base_seq;
      end else if (pick < 95) begin
         r.func = FUNC_ACK;
         r.ack_num = SEQ_W'(sb.next_seq + $urandom_range(0, 3));
      end else begin
         r.func = FUNC_UNUSED;
         r.checksum_ok = 1'($urandom_range(0, 1));
      end
      return r;
   endfunction

   task automatic issue(input req_type r);
      int gap;
      gap = send_idle ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(r);
   endtask

   // Requests that yield no result may still be in flight, so a settling wait follows the drain.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.expected_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input csr_type size);
      csr_if.valid <= 1'b1;
      csr_if.data <= size;
      do @(posedge clock); while (!csr_if.ready);
      sb.size_reg = size;
      csr_if.valid <= 1'b0;
   endtask

   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         gap = recv_idle ? $urandom_range(0, 16) : 0;
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         sb.check_result(rsp_if.data);
      end
   end

   initial begin
      csr_type size;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at the reset window size.
      issue(build_request(FUNC_TIMEOUT, '0, '0, 1'b1, 16'hFFFF));
      issue(build_request(FUNC_ACK, '0, 16'h0000, 1'b1, '0));
      issue(build_request(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF));
      issue(build_request(FUNC_SEND, 64'h0, '0, 1'b0, '0));
      issue(build_request(FUNC_SEND, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0));
      issue(build_request(FUNC_SEND, 64'h5555_5555_5555_5555, '0, 1'b0, '0));
      issue(build_request(FUNC_SEND, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, '0));
      issue(build_request(FUNC_SEND, 64'h0123_4567_89AB_CDEF, '0, 1'b0, '0));
      issue(build_request(FUNC_ACK, '0, 16'd0, 1'b0, '0));
      issue(build_request(FUNC_ACK, '0, 16'hFFFF, 1'b1, '0));
      issue(build_request(FUNC_ACK, '0, 16'd4, 1'b1, '0));
      repeat (4) issue(build_request(FUNC_ACK, '0, 16'd0, 1'b1, '0));
      issue(build_request(FUNC_TIMEOUT, '0, '0, 1'b0, 16'd0));
      issue(build_request(FUNC_ACK, '0, 16'd1, 1'b1, '0));
      issue(build_request(FUNC_ACK, '0, 16'd3, 1'b1, '0));
      settle();
      write_window(4'd0);
      issue(build_request(FUNC_SEND, 64'hDEAD_BEEF_0000_0001, '0, 1'b1, '0));
      settle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: size = 4'd15;
            1: size = 4'd1;
            2: size = 4'd8;
            3: size = 4'd3;
            4: size = 4'd5;
            default: size = 4'd2;
         endcase
         write_window(size);
         send_idle = (p != 2) && (p != 4);
         recv_idle = (p != 3);
         if (p == 2) rsp_hold_cycles = HOLD_CYCLES;
         repeat (PHASE_ITEMS) issue(random_request());
         settle();
      end

      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.expected_events.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
